>>> rtl/core/four_level_ordered_dither_macros.svh
// Assertion macros used by the dither top level.
`ifndef FOUR_LEVEL_ORDERED_DITHER_MACROS_SVH
`define FOUR_LEVEL_ORDERED_DITHER_MACROS_SVH

// Checked at every rising edge of clk while the block is out of reset.
`define OFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define OFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ofd_pkg.sv
// Types, register codes and constant tables of the four-level ordered dither.
package ofd_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_LOG2_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_FIXED_MATRIX = 1'd1;

  typedef struct packed {
    logic [2:0] log2_size;
    logic       use_fixed;
  } ofd_cfg_t;

  // Output grey levels; LVL_1 to LVL_3 are also the threshold multipliers.
  localparam logic [7:0] LVL_0 = 8'd0;
  localparam logic [7:0] LVL_1 = 8'd85;
  localparam logic [7:0] LVL_2 = 8'd170;
  localparam logic [7:0] LVL_3 = 8'd255;

  // Bayer base quadrant code, indexed by (row bit, column bit).
  localparam logic [1:0] QUAD_CODE [2][2] = '{'{2'd0, 2'd2}, '{2'd3, 2'd1}};

  // Fixed 4x4 index matrix, indexed by (row mod 4, column mod 4).
  localparam logic [3:0] FIXED_TAB [4][4] = '{
    '{4'd14, 4'd10, 4'd11, 4'd15},
    '{4'd9,  4'd3,  4'd0,  4'd4},
    '{4'd8,  4'd2,  4'd1,  4'd5},
    '{4'd13, 4'd7,  4'd6,  4'd12}
  };

endpackage

>>> rtl/core/ofd_index.sv
// Dither index lookup: recursive Bayer matrix or the fixed 4x4 matrix.
module ofd_index #(
  parameter int MAX_LOG2_SIZE = 4,
  parameter int ML            = (MAX_LOG2_SIZE < 2) ? 2 : MAX_LOG2_SIZE,
  parameter int LW            = $clog2(ML + 1)
) (
  input  ofd_pkg::ofd_cfg_t cfg,
  input  logic [ML-1:0]     row_lo,
  input  logic [ML-1:0]     col_lo,
  output logic [2*ML-1:0]   idx,
  output logic [LW-1:0]     lg
);
  import ofd_pkg::*;

  logic [2*MAX_LOG2_SIZE-1:0] idx_full;
  logic [LW-1:0]              lg_sat;
  logic [LW-1:0]              shamt;

  // Full-size Bayer index: row/column bit b lands in digit MAX-1-b.
  always_comb begin
    idx_full = '0;
    for (int b = 0; b < MAX_LOG2_SIZE; b++) begin
      idx_full[2*(MAX_LOG2_SIZE-1-b) +: 2] = QUAD_CODE[row_lo[b]][col_lo[b]];
    end
  end

  always_comb begin
    if (cfg.log2_size == 3'd0) begin
      lg_sat = LW'(1);
    end else if (32'(cfg.log2_size) > MAX_LOG2_SIZE) begin
      lg_sat = LW'(MAX_LOG2_SIZE);
    end else begin
      lg_sat = LW'(cfg.log2_size);
    end
  end

  // Dropping the unused low digits leaves the index of the smaller matrix.
  assign shamt = LW'(MAX_LOG2_SIZE) - lg_sat;

  always_comb begin
    if (cfg.use_fixed) begin
      idx = (2*ML)'(FIXED_TAB[row_lo[1:0]][col_lo[1:0]]);
      lg  = LW'(2);
    end else begin
      idx = (2*ML)'(idx_full >> {shamt, 1'b0});
      lg  = lg_sat;
    end
  end

endmodule

>>> rtl/core/ofd_quant.sv
// Exact integer threshold compare that maps a pixel to one of four levels.
module ofd_quant #(
  parameter int ML = 4,
  parameter int LW = 3
) (
  input  logic [7:0]      pixel,
  input  logic [2*ML-1:0] idx,
  input  logic [LW-1:0]   lg,
  output logic [7:0]      level
);
  import ofd_pkg::*;

  localparam int CW = 2*ML + 9;

  logic [CW-1:0] lhs;
  logic [CW-1:0] odd;
  logic [CW-1:0] thr1;
  logic [CW-1:0] thr2;
  logic [CW-1:0] thr3;

  // 2 * N^2 * p is p shifted left by 2*lg+1.
  assign lhs  = CW'(pixel) << {lg, 1'b1};
  assign odd  = CW'({idx, 1'b1});
  assign thr1 = odd * CW'(LVL_1);
  assign thr2 = odd * CW'(LVL_2);
  assign thr3 = odd * CW'(LVL_3);

  always_comb begin
    if (lhs < thr1) begin
      level = LVL_0;
    end else if (lhs < thr2) begin
      level = LVL_1;
    end else if (lhs < thr3) begin
      level = LVL_2;
    end else begin
      level = LVL_3;
    end
  end

endmodule

>>> rtl/core/four_level_ordered_dither.sv
// Top level of the four-level ordered dither: config, input and result registers.
//
//   Channel  Handshake             Payload
//   cfg      cfg_wr_en             cfg_index, cfg_wdata
//   in       in_valid / in_stall   in_pixel_value, in_row_index, in_column_index
//   out      out_valid / out_stall out_dithered_value
//
// One beat can be accepted every cycle while in_stall is low. An accepted beat is
// held in the input register, and its result then passes to the result register.
// The index lookup and the threshold compare sit between the input register
// and the result register, so that single stage sets the cycle time.
// Reset is synchronous and active low; it clears both valid flags and loads the
// register defaults (matrix side 2, Bayer matrix).
// The input stalls only when both the input and the result register hold a beat
// and the result is stalled, so a waiting result blocks an accept only once the
// input register behind it is full as well.
module four_level_ordered_dither #(
  parameter int MAX_LOG2_SIZE = 4,
  parameter int COORD_WIDTH   = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ofd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ofd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_pixel_value,
  input  logic [COORD_WIDTH-1:0]         in_row_index,
  input  logic [COORD_WIDTH-1:0]         in_column_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_dithered_value
);
  import ofd_pkg::*;

  `include "four_level_ordered_dither_macros.svh"

  // The fixed matrix needs a 4x4 side even when the Bayer side is smaller.
  localparam int ML = (MAX_LOG2_SIZE < 2) ? 2 : MAX_LOG2_SIZE;
  localparam int LW = $clog2(ML + 1);

  ofd_cfg_t cfg_r;
  ofd_cfg_t cfg_nxt;

  logic            a_vld_r;
  logic [7:0]      a_pix_r;
  logic [ML-1:0]   a_row_r;
  logic [ML-1:0]   a_col_r;
  logic            out_valid_r;
  logic [7:0]      out_val_r;

  logic [ML-1:0]   row_lo;
  logic [ML-1:0]   col_lo;
  logic [2*ML-1:0] idx;
  logic [LW-1:0]   lg;
  logic [7:0]      level;
  logic            a_load;
  logic            b_load;

  // Configuration writes. Only the register named by the index changes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_MATRIX_LOG2_SIZE: cfg_nxt.log2_size = cfg_wdata[2:0];
        REG_USE_FIXED_MATRIX: cfg_nxt.use_fixed = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{log2_size: 3'd1, use_fixed: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Only the low coordinate bits select the matrix position. Bits beyond the
  // coordinate width read as zero.
  for (genvar b = 0; b < ML; b++) begin : g_coord
    if (b < COORD_WIDTH) begin : g_used
      assign row_lo[b] = in_row_index[b];
      assign col_lo[b] = in_column_index[b];
    end else begin : g_zero
      assign row_lo[b] = 1'b0;
      assign col_lo[b] = 1'b0;
    end
  end

  // The result register loads a held beat whenever it is empty or being drained;
  // the input register loads a valid beat when its beat moves on or it is empty.
  assign b_load   = a_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = a_vld_r && out_valid_r && out_stall;
  assign a_load   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_vld_r <= 1'b1;
      end else if (b_load) begin
        a_vld_r <= 1'b0;
      end
      if (b_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_pix_r <= in_pixel_value;
      a_row_r <= row_lo;
      a_col_r <= col_lo;
    end
    if (b_load) begin
      out_val_r <= level;
    end
  end

  ofd_index #(
    .MAX_LOG2_SIZE(MAX_LOG2_SIZE),
    .ML           (ML),
    .LW           (LW)
  ) u_index (
    .cfg   (cfg_r),
    .row_lo(a_row_r),
    .col_lo(a_col_r),
    .idx   (idx),
    .lg    (lg)
  );

  ofd_quant #(
    .ML(ML),
    .LW(LW)
  ) u_quant (
    .pixel(a_pix_r),
    .idx  (idx),
    .lg   (lg),
    .level(level)
  );

  assign out_valid          = out_valid_r;
  assign out_dithered_value = out_val_r;

  // A reset leaves no result pending.
  `OFD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "result valid after reset")

  // Every result is one of the four grey levels.
  `OFD_ASSERT(a_level_set, out_valid_r |-> (out_val_r == LVL_0 || out_val_r == LVL_1 ||
    out_val_r == LVL_2 || out_val_r == LVL_3), "result is not a legal grey level")

  // Black stays black and white stays white whatever the matrix.
  `OFD_ASSERT(a_black, b_load && a_pix_r == 8'd0 |=> out_val_r == LVL_0, "black not kept")
  `OFD_ASSERT(a_white, b_load && a_pix_r == 8'd255 |=> out_val_r == LVL_3, "white not kept")

  // An accepted beat always occupies the input register on the next cycle.
  `OFD_ASSERT(a_accept_held, in_valid && !in_stall |=> a_vld_r, "accepted beat lost")

endmodule
